// ===== hw/rtl/pixel_format_converter_assert.svh =====
// Assertion macros for the pixel format converter.
// No dependencies; included by files that carry concurrent checks.
`ifndef PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfc_pkg.sv =====
// Shared types and constants for the pixel format converter.
// No dependencies; used by pfc_cfg, pfc_datapath and the top level.
package pfc_pkg;

  localparam int COMP_W     = 8;
  localparam int FMT_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int WEIGHT_W   = 24;
  localparam int PROD_W     = WEIGHT_W + COMP_W;
  localparam int SUM_W      = 32;
  localparam int LUMA_SHIFT = 24;

  localparam logic [FMT_W-1:0] FMT_GRAY8 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB24 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_FORMAT   = 2'd1;

  // luma weights, sum is 2^24
  localparam logic [WEIGHT_W-1:0] LUMA_WR = 24'd5014710;
  localparam logic [WEIGHT_W-1:0] LUMA_WG = 24'd9848226;
  localparam logic [WEIGHT_W-1:0] LUMA_WB = 24'd1914280;

  localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    MODE_LUMA,
    MODE_REPL,
    MODE_COPY,
    MODE_BAD
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic             alpha_en;
    logic [FMT_W-1:0] src_fmt;
    logic [FMT_W-1:0] dst_fmt;
  } conv_ctl_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic s3_valid;
  } pipe_status_t;

endpackage

// ===== hw/rtl/pixel_format_converter.sv =====
// Pixel format converter between gray8, rgb24 and rgba, with a three-stage pipeline.
// Depends on pfc_pkg, pfc_cfg, pfc_datapath and pixel_format_converter_assert.svh.
//
// One pixel word is taken per clock while not stalled; the three luma multiplies
// sit in a stage of their own and the sum and format select in the next, so
// throughput is one word per cycle with no bubbles. out_stall back-pressures the
// whole pipe, and empty stages still fill while the output waits. Formats are set
// through cfg_index 0 (source) and 1 (destination), by the user only while no
// word is in flight; the block does not enforce this. Same-format or
// unknown-format pairs raise out_unsupported with all components zero.
`include "pixel_format_converter_assert.svh"

module pixel_format_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pfc_pkg::COMP_W-1:0]        in_comp0,
  input  logic [pfc_pkg::COMP_W-1:0]        in_comp1,
  input  logic [pfc_pkg::COMP_W-1:0]        in_comp2,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pfc_pkg::COMP_W-1:0]        out_comp0,
  output logic [pfc_pkg::COMP_W-1:0]        out_comp1,
  output logic [pfc_pkg::COMP_W-1:0]        out_comp2,
  output logic [pfc_pkg::COMP_W-1:0]        out_alpha,
  output logic                              out_unsupported
);

  pfc_pkg::conv_ctl_t    ctl;
  pfc_pkg::pipe_status_t status;

  pfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl)
  );

  pfc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_comp0        (in_comp0),
    .in_comp1        (in_comp1),
    .in_comp2        (in_comp2),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_comp0       (out_comp0),
    .out_comp1       (out_comp1),
    .out_comp2       (out_comp2),
    .out_alpha       (out_alpha),
    .out_unsupported (out_unsupported),
    .status          (status)
  );

  // an accepted word must land in stage 1
  `PFC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, status.s1_valid, "accepted word lost at stage 1")

  // unsupported pairs carry an all-zero word
  `PFC_ASSERT_NOW(a_bad_is_zero, clk, rst_n, out_valid && out_unsupported, out_comp0 == '0 && out_comp1 == '0 && out_comp2 == '0 && out_alpha == '0, "unsupported word not zero")

  // gray destination leaves the upper components and alpha clear
  `PFC_ASSERT_NOW(a_gray_dest_clear, clk, rst_n, out_valid && ctl.dst_fmt == pfc_pkg::FMT_GRAY8, out_comp1 == '0 && out_comp2 == '0 && out_alpha == '0, "gray word has extra components")

  // alpha is only ever opaque, and only on a converted word
  `PFC_ASSERT_NOW(a_alpha_opaque, clk, rst_n, out_valid && out_alpha != '0, out_alpha == pfc_pkg::ALPHA_OPAQUE && !out_unsupported && ctl.dst_fmt == pfc_pkg::FMT_RGBA, "bad alpha value")

endmodule

// ===== hw/rtl/pfc_cfg.sv =====
// Format registers and conversion mode decode.
// Depends on pfc_pkg.
module pfc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pfc_pkg::conv_ctl_t                 ctl
);

  logic [pfc_pkg::FMT_W-1:0] src_fmt_r;
  logic [pfc_pkg::FMT_W-1:0] dst_fmt_r;
  logic                      src_colour;
  logic                      dst_colour;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= pfc_pkg::FMT_RGB24;
      dst_fmt_r <= pfc_pkg::FMT_GRAY8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pfc_pkg::REG_SOURCE_FORMAT: src_fmt_r <= cfg_data[pfc_pkg::FMT_W-1:0];
        pfc_pkg::REG_DEST_FORMAT:   dst_fmt_r <= cfg_data[pfc_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  assign src_colour = (src_fmt_r == pfc_pkg::FMT_RGB24) || (src_fmt_r == pfc_pkg::FMT_RGBA);
  assign dst_colour = (dst_fmt_r == pfc_pkg::FMT_RGB24) || (dst_fmt_r == pfc_pkg::FMT_RGBA);

  always_comb begin
    ctl.src_fmt  = src_fmt_r;
    ctl.dst_fmt  = dst_fmt_r;
    ctl.alpha_en = (dst_fmt_r == pfc_pkg::FMT_RGBA);
    if (dst_fmt_r == pfc_pkg::FMT_GRAY8 && src_colour) begin
      ctl.mode = pfc_pkg::MODE_LUMA;
    end else if (dst_colour && src_fmt_r == pfc_pkg::FMT_GRAY8) begin
      ctl.mode = pfc_pkg::MODE_REPL;
    end else if (dst_colour && src_colour && dst_fmt_r != src_fmt_r) begin
      ctl.mode = pfc_pkg::MODE_COPY;
    end else begin
      ctl.mode = pfc_pkg::MODE_BAD;
    end
  end

endmodule

// ===== hw/rtl/pfc_datapath.sv =====
// Three-stage conversion pipeline: capture, luma products, sum and select.
// Depends on pfc_pkg; control comes from pfc_cfg.
module pfc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfc_pkg::conv_ctl_t            ctl,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfc_pkg::COMP_W-1:0]    in_comp0,
  input  logic [pfc_pkg::COMP_W-1:0]    in_comp1,
  input  logic [pfc_pkg::COMP_W-1:0]    in_comp2,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfc_pkg::COMP_W-1:0]    out_comp0,
  output logic [pfc_pkg::COMP_W-1:0]    out_comp1,
  output logic [pfc_pkg::COMP_W-1:0]    out_comp2,
  output logic [pfc_pkg::COMP_W-1:0]    out_alpha,
  output logic                          out_unsupported,
  output pfc_pkg::pipe_status_t         status
);

  localparam int CW = pfc_pkg::COMP_W;
  localparam int PW = pfc_pkg::PROD_W;

  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  // stage 1
  logic [CW-1:0]      s1_c0_r, s1_c1_r, s1_c2_r;
  pfc_pkg::mode_t     s1_mode_r;
  logic               s1_alpha_r;
  // stage 2
  logic [CW-1:0]      s2_c0_r, s2_c1_r, s2_c2_r;
  logic [PW-1:0]      s2_pr_r, s2_pg_r, s2_pb_r;
  pfc_pkg::mode_t     s2_mode_r;
  logic               s2_alpha_r;
  // stage 3 (output word)
  logic [CW-1:0]      o_c0_r, o_c1_r, o_c2_r, o_a_r;
  logic               o_bad_r;
  logic [CW-1:0]      o_c0_nxt, o_c1_nxt, o_c2_nxt, o_a_nxt;
  logic               o_bad_nxt;
  logic [pfc_pkg::SUM_W-1:0] luma_sum;

  // a stage advances when empty or when the one after it advances
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_c0_r    <= in_comp0;
      s1_c1_r    <= in_comp1;
      s1_c2_r    <= in_comp2;
      s1_mode_r  <= ctl.mode;
      s1_alpha_r <= ctl.alpha_en;
    end
    if (en2) begin
      s2_c0_r    <= s1_c0_r;
      s2_c1_r    <= s1_c1_r;
      s2_c2_r    <= s1_c2_r;
      s2_pr_r    <= PW'(pfc_pkg::LUMA_WR) * PW'(s1_c0_r);
      s2_pg_r    <= PW'(pfc_pkg::LUMA_WG) * PW'(s1_c1_r);
      s2_pb_r    <= PW'(pfc_pkg::LUMA_WB) * PW'(s1_c2_r);
      s2_mode_r  <= s1_mode_r;
      s2_alpha_r <= s1_alpha_r;
    end
    if (en3) begin
      o_c0_r  <= o_c0_nxt;
      o_c1_r  <= o_c1_nxt;
      o_c2_r  <= o_c2_nxt;
      o_a_r   <= o_a_nxt;
      o_bad_r <= o_bad_nxt;
    end
  end

  // weights sum to 2^24, so the top byte never overflows
  assign luma_sum = pfc_pkg::SUM_W'(s2_pr_r) + pfc_pkg::SUM_W'(s2_pg_r)
                  + pfc_pkg::SUM_W'(s2_pb_r);

  always_comb begin
    o_c0_nxt  = '0;
    o_c1_nxt  = '0;
    o_c2_nxt  = '0;
    o_a_nxt   = '0;
    o_bad_nxt = 1'b0;
    unique case (s2_mode_r)
      pfc_pkg::MODE_LUMA: begin
        o_c0_nxt = luma_sum[pfc_pkg::LUMA_SHIFT +: CW];
      end
      pfc_pkg::MODE_REPL: begin
        o_c0_nxt = s2_c0_r;
        o_c1_nxt = s2_c0_r;
        o_c2_nxt = s2_c0_r;
        o_a_nxt  = s2_alpha_r ? pfc_pkg::ALPHA_OPAQUE : '0;
      end
      pfc_pkg::MODE_COPY: begin
        o_c0_nxt = s2_c0_r;
        o_c1_nxt = s2_c1_r;
        o_c2_nxt = s2_c2_r;
        o_a_nxt  = s2_alpha_r ? pfc_pkg::ALPHA_OPAQUE : '0;
      end
      pfc_pkg::MODE_BAD: begin
        o_bad_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid       = v3_r;
  assign out_comp0       = o_c0_r;
  assign out_comp1       = o_c1_r;
  assign out_comp2       = o_c2_r;
  assign out_alpha       = o_a_r;
  assign out_unsupported = o_bad_r;

  assign status.s1_valid = v1_r;
  assign status.s2_valid = v2_r;
  assign status.s3_valid = v3_r;

endmodule
